FILE: hw/rtl/upd_pkg.sv
`default_nettype none

package upd_pkg;

  // character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_QUERY   = 8'h3F;

  // final status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ESCAPE = 2'd1,
    ST_DOTDOT     = 2'd2,
    ST_NO_SLASH   = 2'd3
  } status_t;

  // escape decoder phase
  typedef enum logic [1:0] {
    PH_NORMAL   = 2'd0,
    PH_HEX_HIGH = 2'd1,
    PH_HEX_LOW  = 2'd2
  } phase_t;

  // per-uri decoder state
  typedef struct packed {
    phase_t     phase;
    logic [3:0] high_nibble;
    logic       prev_dot;
    logic       query_seen;
    logic       any_output;
    logic       first_slash;
    logic       dotdot;
    logic       esc_err;
  } state_t;

  // one result beat
  typedef struct packed {
    logic [7:0] byte_val;
    logic       byte_valid;
    logic       in_query;
    logic       is_last;
    status_t    status;
  } result_t;

  // hex digit check and value
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok = 1'b1;
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/upd_step.sv
`default_nettype none

module upd_step (
  input  wire upd_pkg::state_t  state,
  input  wire logic [7:0]       char_code,
  input  wire logic             end_marker,
  output upd_pkg::state_t       state_nxt,
  output logic                  res_valid,
  output upd_pkg::result_t      res
);
  import upd_pkg::*;

  hex_t       hx;
  logic       emit;
  logic [7:0] eb;
  logic       q_nxt;

  assign hx = hex_digit(char_code);

  // escape sequencing and pick of the byte to emit
  always_comb begin
    state_nxt = state;
    emit      = 1'b0;
    eb        = char_code;
    if (end_marker) begin
      state_nxt = '0;
    end else if (!state.esc_err) begin
      unique case (state.phase)
        PH_HEX_HIGH: begin
          if (!hx.ok) begin
            state_nxt.esc_err = 1'b1;
            state_nxt.phase   = PH_NORMAL;
          end else begin
            state_nxt.high_nibble = hx.val;
            state_nxt.phase       = PH_HEX_LOW;
          end
        end
        PH_HEX_LOW: begin
          state_nxt.phase = PH_NORMAL;
          if (!hx.ok) begin
            state_nxt.esc_err = 1'b1;
          end else begin
            emit = 1'b1;
            eb   = {state.high_nibble, hx.val};
          end
        end
        default: begin
          // normal characters, also the unused phase code
          if (char_code == CH_PERCENT) begin
            state_nxt.phase = PH_HEX_HIGH;
          end else begin
            state_nxt.phase = PH_NORMAL;
            emit            = 1'b1;
            eb              = (char_code == CH_PLUS) ? CH_SPACE : char_code;
          end
        end
      endcase
    end

    // path tracking on emitted bytes
    q_nxt = state.query_seen | (eb == CH_QUERY);
    if (emit) begin
      state_nxt.query_seen = q_nxt;
      if (!q_nxt && eb == CH_DOT && state.prev_dot) begin
        state_nxt.dotdot = 1'b1;
      end
      state_nxt.prev_dot = (eb == CH_DOT);
      if (!state.any_output) begin
        state_nxt.first_slash = (eb == CH_SLASH);
        state_nxt.any_output  = 1'b1;
      end
    end
  end

  // result beat
  always_comb begin
    res_valid      = emit | end_marker;
    res.byte_val   = end_marker ? 8'd0 : eb;
    res.byte_valid = !end_marker;
    res.in_query   = !end_marker && q_nxt;
    res.is_last    = end_marker;
    res.status     = ST_OK;
    if (end_marker) begin
      priority if (state.esc_err || state.phase == PH_HEX_HIGH ||
                   state.phase == PH_HEX_LOW) begin
        res.status = ST_BAD_ESCAPE;
      end else if (state.dotdot) begin
        res.status = ST_DOTDOT;
      end else if (!state.any_output || !state.first_slash) begin
        res.status = ST_NO_SLASH;
      end else begin
        res.status = ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/uri_percent_decoder_path_check_core.sv
// an input beat passes the input register, then the result register, on its way to its result beat
// throughput: one input beat per cycle while the result side keeps flowing
// bytes of an escape before its last digit, and bytes after a bad escape, give no result
// the end beat gives one status beat and returns the decoder state to reset
// rst_n (synchronous, active low) clears both valid flags and the decoder state
`default_nettype none

module uri_percent_decoder_path_check_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_end_marker,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_in_query,
  output logic             out_is_last,
  output logic [1:0]       out_status
);
  import upd_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_end_r;
  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  logic       res_valid;
  result_t    res;
  logic       out_free;
  logic       s1_fire;
  logic       in_accept;

  // handshake control
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // per-beat decode
  upd_step u_step (
    .state      (state_r),
    .char_code  (s1_char_r),
    .end_marker (s1_end_r),
    .state_nxt  (state_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  // next valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_fire && res_valid;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char_r <= in_char_code;
      s1_end_r  <= in_end_marker;
    end
    if (s1_fire && res_valid && out_free) begin
      out_r <= res;
    end
  end

  // output ports
  assign out_valid      = out_valid_r;
  assign out_byte       = out_r.byte_val;
  assign out_byte_valid = out_r.byte_valid;
  assign out_in_query   = out_r.in_query;
  assign out_is_last    = out_r.is_last;
  assign out_status     = out_r.status;

`ifndef NO_ASSERTIONS
  // end beat puts the decoder back to reset
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_end_r |=> state_r == '0)
    else $error("decoder state not cleared after end beat");

  // no byte results once an escape has gone bad
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_end_r && state_r.esc_err |-> !res_valid)
    else $error("byte emitted after bad escape");

  // a result carries either a byte or a status, never both
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.byte_valid != out_r.is_last) &&
                    (out_r.byte_valid ? out_r.status == ST_OK : out_r.byte_val == 8'd0))
    else $error("malformed result beat");

  // input is held back only while the stage register is occupied and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  // one stimulus row: a raw byte or the end beat, with an optional fixed answer
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       in_end_marker;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_in_query;
  logic       out_is_last;
  logic [1:0] out_status;

  // shadow decoder state
  phase_t     dec_phase;
  logic [3:0] dec_high;
  logic       dec_prev_dot;
  logic       dec_query;
  logic       dec_any;
  logic       dec_first_slash;
  logic       dec_dotdot;
  logic       dec_bad;

  result_t    decoded_beats[$];
  stim_row_t  directed_rows[$];
  stim_row_t  uri_beats[$];
  int         mismatches = 0;
  int         idle_odds = 0;
  int         stall_left = 0;
  int         beats_sent = 0;

  uri_percent_decoder_path_check_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_end_marker  (in_end_marker),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_in_query   (out_in_query),
    .out_is_last    (out_is_last),
    .out_status     (out_status)
  );

  always #2 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report(input string msg);
    if (mismatches < 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // hex digit: bit 4 says valid, low nibble is the value
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [7:0] lc;
    lc = ch | 8'h20;
    if (ch >= "0" && ch <= "9") return {1'b1, ch[3:0]};
    if (lc >= "a" && lc <= "f") return {1'b1, 4'(lc - "a" + 8'd10)};
    return 5'b0;
  endfunction

  task automatic clear_decoder();
    dec_phase       = PH_NORMAL;
    dec_high        = 4'd0;
    dec_prev_dot    = 1'b0;
    dec_query       = 1'b0;
    dec_any         = 1'b0;
    dec_first_slash = 1'b0;
    dec_dotdot      = 1'b0;
    dec_bad         = 1'b0;
  endtask

  // a decoded byte goes out and updates the path flags
  task automatic emit_byte(input logic [7:0] b, output result_t r);
    if (!dec_query && b == CH_QUERY) dec_query = 1'b1;
    if (!dec_query && b == CH_DOT && dec_prev_dot) dec_dotdot = 1'b1;
    dec_prev_dot = (b == CH_DOT);
    if (!dec_any) begin
      dec_first_slash = (b == CH_SLASH);
      dec_any         = 1'b1;
    end
    r            = '0;
    r.byte_val   = b;
    r.byte_valid = 1'b1;
    r.in_query   = dec_query;
    r.status     = ST_OK;
  endtask

  // predicted response to one accepted beat
  task automatic decode_step(input logic [7:0] ch, input logic last,
                             output logic made, output result_t r);
    logic [4:0] hx;
    made = 1'b0;
    r    = '0;
    if (last) begin
      made      = 1'b1;
      r.is_last = 1'b1;
      if (dec_bad || dec_phase != PH_NORMAL) r.status = ST_BAD_ESCAPE;
      else if (dec_dotdot) r.status = ST_DOTDOT;
      else if (!dec_any || !dec_first_slash) r.status = ST_NO_SLASH;
      else r.status = ST_OK;
      clear_decoder();
    end else if (dec_bad) begin
      made = 1'b0;
    end else if (dec_phase != PH_NORMAL) begin
      hx = hex_nibble(ch);
      if (!hx[4]) begin
        dec_bad   = 1'b1;
        dec_phase = PH_NORMAL;
      end else if (dec_phase == PH_HEX_HIGH) begin
        dec_high  = hx[3:0];
        dec_phase = PH_HEX_LOW;
      end else begin
        dec_phase = PH_NORMAL;
        emit_byte({dec_high, hx[3:0]}, r);
        made = 1'b1;
      end
    end else if (ch == CH_PERCENT) begin
      dec_phase = PH_HEX_HIGH;
    end else begin
      emit_byte((ch == CH_PLUS) ? CH_SPACE : ch, r);
      made = 1'b1;
    end
  endtask

  task automatic row(input logic [7:0] ch, input logic last, input logic typed,
                     input logic [7:0] b, input logic v, input logic q,
                     input logic l, input status_t st);
    stim_row_t s;
    s.ch              = ch;
    s.last            = last;
    s.typed           = typed;
    s.want.byte_val   = b;
    s.want.byte_valid = v;
    s.want.in_query   = q;
    s.want.is_last    = l;
    s.want.status     = st;
    directed_rows.push_back(s);
  endtask

  task automatic push_char(input logic [7:0] ch, input logic last);
    stim_row_t s;
    s       = '0;
    s.ch    = ch;
    s.last  = last;
    uri_beats.push_back(s);
  endtask

  // hex digit character in random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] v;
    logic [4:0] hx;
    v  = 8'($urandom_range(0, 255));
    hx = hex_nibble(v);
    while (hx[4]) begin
      v  = 8'($urandom_range(0, 255));
      hx = hex_nibble(v);
    end
    return v;
  endfunction

  // one piece of a plausible path or query
  task automatic add_element();
    int         roll;
    logic [7:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      push_char(8'("a") + 8'($urandom_range(0, 25)), 1'b0);
    end else if (roll < 50) begin
      push_char(CH_SLASH, 1'b0);
    end else if (roll < 62) begin
      push_char(CH_DOT, 1'b0);
    end else if (roll < 68) begin
      push_char(CH_QUERY, 1'b0);
    end else if (roll < 74) begin
      push_char(CH_PLUS, 1'b0);
    end else if (roll < 90) begin
      v = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: v = CH_DOT;
          1: v = CH_QUERY;
          default: v = CH_SLASH;
        endcase
      end
      push_char(CH_PERCENT, 1'b0);
      push_char(hex_char(v[7:4]), 1'b0);
      push_char(hex_char(v[3:0]), 1'b0);
    end else begin
      push_char(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // one uri: mostly well formed, some with a bad or cut-off escape
  task automatic build_uri();
    int n;
    int fault;
    n     = $urandom_range(0, 10);
    fault = ($urandom_range(0, 99) < 25) ? $urandom_range(1, 4) : 0;
    if ($urandom_range(0, 9) != 0) push_char(CH_SLASH, 1'b0);
    for (int i = 0; i < n; i++) add_element();
    case (fault)
      1: begin
        push_char(CH_PERCENT, 1'b0);
        push_char(non_hex_char(), 1'b0);
      end
      2: begin
        push_char(CH_PERCENT, 1'b0);
        push_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
        push_char(non_hex_char(), 1'b0);
      end
      3: push_char(CH_PERCENT, 1'b0);
      4: begin
        push_char(CH_PERCENT, 1'b0);
        push_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
      end
      default: ;
    endcase
    if (fault == 1 || fault == 2) begin
      for (int i = 0; i < 3; i++) add_element();
    end
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // random gap on the sending side, with junk on the idle bus
  task automatic pause_sender();
    if ($urandom_range(0, 99) < idle_odds) begin
      in_valid      <= 1'b0;
      in_char_code  <= 8'($urandom_range(0, 255));
      in_end_marker <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // drive one beat until accepted, then predict
  task automatic send_beat(input stim_row_t s);
    logic    made;
    result_t r;
    in_valid      <= 1'b1;
    in_char_code  <= s.ch;
    in_end_marker <= s.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_step(s.ch, s.last, made, r);
    if (s.typed) decoded_beats.push_back(s.want);
    else if (made) decoded_beats.push_back(r);
    beats_sent++;
    @(negedge clk);
  endtask

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (rst_n && $urandom_range(0, 99) < idle_odds) stall_left = $urandom_range(1, 12);
    end
  end

  // result checking
  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_beats.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        w = decoded_beats.pop_front();
        if (out_byte !== w.byte_val)
          report($sformatf("out_byte %h, expected %h", out_byte, w.byte_val));
        if (out_byte_valid !== w.byte_valid)
          report($sformatf("out_byte_valid %b, expected %b", out_byte_valid, w.byte_valid));
        if (out_in_query !== w.in_query)
          report($sformatf("out_in_query %b, expected %b", out_in_query, w.in_query));
        if (out_is_last !== w.is_last)
          report($sformatf("out_is_last %b, expected %b", out_is_last, w.is_last));
        if (out_status !== w.status)
          report($sformatf("out_status %0d, expected %0d", out_status, w.status));
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_char_code  = 8'h00;
    in_end_marker = 1'b0;
    out_stall     = 1'b0;
    clear_decoder();

    // empty uri, plain and escaped bytes, extremes and every error status
    row(8'hFF,      1, 1, 8'h00,    0, 0, 1, ST_NO_SLASH);
    row(CH_SLASH,   0, 1, CH_SLASH, 1, 0, 0, ST_OK);
    row(CH_PERCENT, 0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("4",        0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("1",        0, 0, 8'h00,    0, 0, 0, ST_OK);
    row(CH_PLUS,    0, 1, CH_SPACE, 1, 0, 0, ST_OK);
    row(CH_PERCENT, 0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("f",        0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("F",        0, 1, 8'hFF,    1, 0, 0, ST_OK);
    row(CH_DOT,     0, 0, 8'h00,    0, 0, 0, ST_OK);
    row(CH_PERCENT, 0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("2",        0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("e",        0, 0, 8'h00,    0, 0, 0, ST_OK);
    row(CH_PERCENT, 0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("3",        0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("F",        0, 0, 8'h00,    0, 0, 0, ST_OK);
    row(8'h00,      0, 1, 8'h00,    1, 1, 0, ST_OK);
    row(8'h00,      1, 1, 8'h00,    0, 0, 1, ST_DOTDOT);
    row(CH_PERCENT, 0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("g",        0, 0, 8'h00,    0, 0, 0, ST_OK);
    row("x",        0, 0, 8'h00,    0, 0, 0, ST_OK);
    row(8'hFF,      1, 1, 8'h00,    0, 0, 1, ST_BAD_ESCAPE);
    row(CH_SLASH,   0, 1, CH_SLASH, 1, 0, 0, ST_OK);
    row(CH_PERCENT, 0, 0, 8'h00,    0, 0, 0, ST_OK);
    row(8'h00,      1, 1, 8'h00,    0, 0, 1, ST_BAD_ESCAPE);
    row("a",        0, 1, "a",      1, 0, 0, ST_OK);
    row(8'h00,      1, 1, 8'h00,    0, 0, 1, ST_NO_SLASH);

    // synchronous reset, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_odds = 15;
    foreach (directed_rows[i]) begin
      pause_sender();
      send_beat(directed_rows[i]);
    end

    // random uris, with idling that varies per uri and stops near the end
    while (beats_sent < 440) begin
      if (beats_sent > 370) idle_odds = 0;
      else begin
        case ($urandom_range(0, 3))
          0: idle_odds = 0;
          1: idle_odds = 10;
          2: idle_odds = 25;
          default: idle_odds = 50;
        endcase
      end
      build_uri();
      while (uri_beats.size() != 0) begin
        pause_sender();
        send_beat(uri_beats.pop_front());
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for the pipeline
    while (decoded_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && decoded_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/upd_pkg.sv
hw/rtl/upd_step.sv
hw/rtl/uri_percent_decoder_path_check_core.sv
bench/testbench.sv
